FILE: hdl/mac_vlan_learning_table_top_assert.svh
// assertion macros used by the top rtl file
`ifndef MAC_VLAN_LEARNING_TABLE_TOP_ASSERT_SVH
`define MAC_VLAN_LEARNING_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define MVLT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define MVLT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MVLT_ASSERT(lbl, prop, msg)
`define MVLT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hdl/mvlt_pkg.sv
`default_nettype none

package mvlt_pkg;

   // field widths of the request and response words
   localparam int MAC_W    = 48;
   localparam int VLAN_W   = 12;
   localparam int PORT_W   = 8;
   localparam int STATUS_W = 3;
   localparam int BUCKET_W = 10;
   localparam int KEY_W    = VLAN_W + MAC_W;

   // hash word width
   localparam int HASH_W   = 32;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

`default_nettype wire

FILE: hdl/mvlt_req_if.sv
`default_nettype none

interface mvlt_req_if import mvlt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [MAC_W-1:0]  mac_addr;
   logic [VLAN_W-1:0] vlan;
   logic [PORT_W-1:0] port;

   modport source (output valid, output func, output mac_addr, output vlan, output port,
                   input ready);
   modport sink   (input valid, input func, input mac_addr, input vlan, input port,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/mvlt_rsp_if.sv
`default_nettype none

interface mvlt_rsp_if import mvlt_pkg::*; ();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [BUCKET_W-1:0] bucket;

   modport source (output valid, output status, output bucket, input ready);
   modport sink   (input valid, input status, input bucket, output ready);
endinterface

`default_nettype wire

FILE: hdl/mvlt_bucket_mod.sv
`default_nettype none

module mvlt_bucket_mod import mvlt_pkg::*; #(
   parameter int BUCKETS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [HASH_W-1:0]          value,
   output logic [$clog2(BUCKETS)-1:0] remainder,
   output mod_status_type             status
);

   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam logic [HASH_W-1:0] DIVISOR = HASH_W'(BUCKETS);
   // floor(2^32 / BUCKETS): the quotient estimate is never high and at most one low
   localparam logic [HASH_W-1:0] RECIP   = HASH_W'((64'd1 << HASH_W) / BUCKETS);

   typedef enum logic [1:0] {
      M_IDLE,
      M_QUOT,
      M_BACK,
      M_FIX
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [HASH_W-1:0]      val_ff, val_in;
   logic [2*HASH_W-1:0]    prod_ff, prod_in;
   logic [BUCKET_BITS-1:0] rem_ff, rem_in;
   logic                   done_ff, done_in;
   logic [HASH_W-1:0]      mul_a, mul_b;
   logic [2*HASH_W-1:0]    product;
   logic [HASH_W-1:0]      diff, rem_fix;

   // shared multiplier: value by reciprocal, then quotient estimate by bucket count
   always_comb begin
      if (phase_ff == M_QUOT) begin
         mul_a = val_ff;
         mul_b = RECIP;
      end else begin
         mul_a = prod_ff[2*HASH_W-1:HASH_W];
         mul_b = DIVISOR;
      end
   end

   assign product = (2*HASH_W)'(mul_a) * (2*HASH_W)'(mul_b);

   // remainder, corrected once when the estimate came out one low
   assign diff    = val_ff - prod_ff[HASH_W-1:0];
   assign rem_fix = (diff >= DIVISOR) ? (diff - DIVISOR) : diff;

   // step sequencing
   always_comb begin
      phase_in = phase_ff;
      val_in   = val_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         M_IDLE: begin
            if (start) begin
               val_in   = value;
               phase_in = M_QUOT;
            end
         end
         M_QUOT: begin
            prod_in  = product;
            phase_in = M_BACK;
         end
         M_BACK: begin
            prod_in  = product;
            phase_in = M_FIX;
         end
         M_FIX: begin
            rem_in   = rem_fix[BUCKET_BITS-1:0];
            done_in  = 1'b1;
            phase_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      val_ff  <= val_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign remainder   = rem_ff;
   assign status.busy = (phase_ff != M_IDLE);
   assign status.done = done_ff;

endmodule

`default_nettype wire

FILE: hdl/mac_vlan_learning_table_top.sv
// mac/vlan address learning table
//
// req_ch carries one insert (func 0) or delete (func 1) word: mac_addr, vlan, port.
// rsp_ch returns one word per request: status and the bucket the key hashed to.
// Both channels move a word when valid and ready are high at a rising edge.
//
// A request is handled one at a time. The modulo unit forms the bucket remainder
// in steps (reciprocal multiply, back multiply through one shared multiplier, then
// one correction), then the valid row of the bucket is read and the ways are read
// and compared one after another through a single key comparator; the search stops
// at the first matching way. A new request can be taken as soon as the response
// is posted.
//
// The response sits in an output register. A new request is taken while it waits;
// that request is held in its write step until the old response is taken.
//
// After reset the valid rows are swept clear, one bucket per cycle; req_ch.ready
// stays low during the sweep.
`default_nettype none
`include "mac_vlan_learning_table_top_assert.svh"

module mac_vlan_learning_table_top import mvlt_pkg::*; #(
   parameter int BUCKETS   = 1024,
   parameter int WAYS      = 4,
   parameter int PORT_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   mvlt_req_if.sink   req_ch,
   mvlt_rsp_if.source rsp_ch
);

   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int ENTRIES     = BUCKETS * WAYS;
   localparam int ENTRY_BITS  = $clog2(ENTRIES);
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [WAY_BITS-1:0]    LAST_WAY   = WAY_BITS'(WAYS - 1);
   localparam logic [BUCKET_BITS-1:0] LAST_BKT   = BUCKET_BITS'(BUCKETS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_VREAD,
      S_KREAD,
      S_CMP,
      S_WRITE
   } state_type;

   // table storage
   logic [WAYS-1:0]      valid_mem [BUCKETS];
   logic [KEY_W-1:0]     key_mem   [ENTRIES];
   logic [PORT_BITS-1:0] port_mem  [ENTRIES];

   state_type            state_ff, state_in;
   logic [BUCKET_BITS-1:0] clr_ff, clr_in;
   logic                 func_ff, func_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PORT_BITS-1:0] port_ff, port_in;
   logic [BUCKET_BITS-1:0] bucket_ff, bucket_in;
   logic [ENTRY_BITS-1:0] base_ff, base_in;
   logic [WAY_BITS-1:0]  way_ff, way_in;
   logic                 hit_ff, hit_in;
   logic [WAY_BITS-1:0]  hit_way_ff, hit_way_in;
   logic                 free_ff, free_in;
   logic [WAY_BITS-1:0]  free_way_ff, free_way_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [BUCKET_W-1:0]  rsp_bucket_ff, rsp_bucket_in;

   // memory read data
   logic [WAYS-1:0]      valid_rd_ff;
   logic [KEY_W-1:0]     key_rd_ff;
   logic [PORT_BITS-1:0] port_rd_ff;

   // memory control
   logic                   vm_rd, vm_we, km_rd, km_we, pm_we;
   logic [BUCKET_BITS-1:0] vm_waddr;
   logic [WAYS-1:0]        vm_wdata, row_mod;
   logic [WAY_BITS-1:0]    wr_way;
   logic [ENTRY_BITS-1:0]  wr_addr, rd_addr;

   logic                   mod_start;
   logic [HASH_W-1:0]      hash_val;
   logic [BUCKET_BITS-1:0] mod_rem;
   mod_status_type         mod_st;

   logic out_free, way_valid, key_eq, port_eq, last_way;

   // bucket hash: vlan ^ mac bytes 0-1 ^ mac bytes 2-5
   assign hash_val = HASH_W'(req_ch.vlan) ^ HASH_W'(req_ch.mac_addr[15:0])
                   ^ req_ch.mac_addr[47:16];

   mvlt_bucket_mod #(
      .BUCKETS (BUCKETS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .value     (hash_val),
      .remainder (mod_rem),
      .status    (mod_st)
   );

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.bucket = rsp_bucket_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // shared way compare
   assign way_valid = valid_rd_ff[way_ff];
   assign key_eq    = (key_rd_ff == key_ff);
   assign port_eq   = (port_rd_ff == port_ff);
   assign last_way  = (way_ff == LAST_WAY);

   assign wr_way  = hit_ff ? hit_way_ff : free_way_ff;
   assign wr_addr = base_ff + ENTRY_BITS'(wr_way);
   assign rd_addr = base_ff + ENTRY_BITS'(way_ff);

   // valid row with the written way set on insert, cleared on delete
   always_comb begin
      row_mod         = valid_rd_ff;
      row_mod[wr_way] = !func_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      port_in       = port_ff;
      bucket_in     = bucket_ff;
      base_in       = base_ff;
      way_in        = way_ff;
      hit_in        = hit_ff;
      hit_way_in    = hit_way_ff;
      free_in       = free_ff;
      free_way_in   = free_way_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      mod_start     = 1'b0;
      vm_rd         = 1'b0;
      vm_we         = 1'b0;
      vm_waddr      = bucket_ff;
      vm_wdata      = row_mod;
      km_rd         = 1'b0;
      km_we         = 1'b0;
      pm_we         = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            vm_we    = 1'b1;
            vm_waddr = clr_ff;
            vm_wdata = '0;
            clr_in   = clr_ff + BUCKET_BITS'(1);
            if (clr_ff == LAST_BKT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               mod_start = 1'b1;
               func_in   = req_ch.func;
               key_in    = {req_ch.vlan, req_ch.mac_addr};
               port_in   = PORT_BITS'(req_ch.port);
               hit_in    = 1'b0;
               free_in   = 1'b0;
               way_in    = '0;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            if (mod_st.done) begin
               bucket_in = mod_rem;
               state_in  = S_VREAD;
            end
         end
         S_VREAD: begin
            vm_rd    = 1'b1;
            base_in  = ENTRY_BITS'(bucket_ff * WAYS);
            state_in = S_KREAD;
         end
         S_KREAD: begin
            km_rd    = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!func_ff) begin
               if (way_valid && key_eq) begin
                  hit_in     = 1'b1;
                  hit_way_in = way_ff;
                  state_in   = S_WRITE;
               end else begin
                  if (!way_valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_way_in = way_ff;
                  end
                  if (last_way) begin
                     state_in = S_WRITE;
                  end else begin
                     way_in   = way_ff + WAY_BITS'(1);
                     state_in = S_KREAD;
                  end
               end
            end else begin
               if (way_valid && key_eq && port_eq) begin
                  hit_in     = 1'b1;
                  hit_way_in = way_ff;
                  state_in   = S_WRITE;
               end else if (last_way) begin
                  state_in = S_WRITE;
               end else begin
                  way_in   = way_ff + WAY_BITS'(1);
                  state_in = S_KREAD;
               end
            end
         end
         S_WRITE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = BUCKET_W'(bucket_ff);
               if (!func_ff) begin
                  if (hit_ff) begin
                     pm_we         = 1'b1;
                     rsp_status_in = ST_UPDATED;
                  end else if (free_ff) begin
                     km_we         = 1'b1;
                     pm_we         = 1'b1;
                     vm_we         = 1'b1;
                     rsp_status_in = ST_INSERTED;
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end else if (hit_ff) begin
                  vm_we         = 1'b1;
                  rsp_status_in = ST_DELETED;
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      key_ff        <= key_in;
      port_ff       <= port_in;
      bucket_ff     <= bucket_in;
      base_ff       <= base_in;
      way_ff        <= way_in;
      hit_ff        <= hit_in;
      hit_way_ff    <= hit_way_in;
      free_ff       <= free_in;
      free_way_ff   <= free_way_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   // valid rows, one per bucket
   always_ff @(posedge clock) begin
      if (vm_we) begin
         valid_mem[vm_waddr] <= vm_wdata;
      end
      if (vm_rd) begin
         valid_rd_ff <= valid_mem[bucket_ff];
      end
   end

   // key and port entries, one per way
   always_ff @(posedge clock) begin
      if (km_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (pm_we) begin
         port_mem[wr_addr] <= port_ff;
      end
      if (km_rd) begin
         key_rd_ff  <= key_mem[rd_addr];
         port_rd_ff <= port_mem[rd_addr];
      end
   end

   `MVLT_ASSERT_RST(a_reset_state, $past(reset) |-> (!rsp_valid_ff && state_ff == S_CLEAR), "reset did not clear control")
   `MVLT_ASSERT(a_done_in_hash, mod_st.done |-> (state_ff == S_HASH), "modulo result outside hash wait")
   `MVLT_ASSERT(a_idle_no_write, (state_ff == S_IDLE) |-> !(vm_we || km_we || pm_we), "table write while idle")
   `MVLT_ASSERT(a_status_code, rsp_valid_ff |-> (rsp_status_ff <= ST_FULL), "undefined status code")
   `MVLT_ASSERT(a_result_posted, (state_ff == S_WRITE && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE), "result not posted")

endmodule

`default_nettype wire

FILE: test/mac_vlan_learning_table_top_tb.sv
`timescale 1ns / 1ps

module mac_vlan_learning_table_top_tb;
   import mvlt_pkg::*;

   localparam int BUCKETS   = 1024;
   localparam int WAYS      = 4;
   localparam int PORT_BITS = 8;
   localparam int ENTRIES   = BUCKETS * WAYS;

   // request operations
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // directed bucket: twin macs cancel in the hash, so the bucket is the vlan
   localparam logic [VLAN_W-1:0] DIR_VLAN  = 12'h005;
   localparam logic [VLAN_W-1:0] WIDE_VLAN = 12'h805;
   localparam logic [MAC_W-1:0]  MAC_TOP   = 48'h8000_0000_0000;

   // random phases: idle percentages of sender and receiver
   localparam int PHASES        = 4;
   localparam int WORDS_PER_PHASE = 200;
   localparam int SEND_IDLE_PCT [PHASES] = '{0, 59, 0, 24};
   localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 59, 24};
   localparam int HOT_N         = 8;
   localparam int KEY_POOL_MAX  = 32;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct packed {
      logic                func;
      logic [MAC_W-1:0]    mac;
      logic [VLAN_W-1:0]   vlan;
      logic [PORT_W-1:0]   port;
      logic                typed;
      status_type          status;
      logic [BUCKET_W-1:0] bucket;
   } learn_row_t;

   typedef struct packed {
      status_type          status;
      logic [BUCKET_W-1:0] bucket;
   } learn_rsp_t;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [VLAN_W-1:0] vlan;
      logic [PORT_W-1:0] port;
   } learned_key_t;

   logic clock;
   logic reset;

   mvlt_req_if req_ch ();
   mvlt_rsp_if rsp_ch ();

   mac_vlan_learning_table_top #(
      .BUCKETS   (BUCKETS),
      .WAYS      (WAYS),
      .PORT_BITS (PORT_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow of the address table
   bit                     tbl_valid [ENTRIES];
   logic [KEY_W-1:0]       tbl_key   [ENTRIES];
   logic [PORT_BITS-1:0]   tbl_port  [ENTRIES];

   learn_rsp_t   awaited_rsp [$];
   learned_key_t learned_keys [$];
   learn_row_t   plan [22];
   int           hot_bucket [HOT_N];
   int           mismatches = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   // typed expectation riding along with the word on the request channel
   logic                row_typed;
   status_type          row_status;
   logic [BUCKET_W-1:0] row_bucket;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog
   initial begin
      #(5_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int hash_bucket(input logic [MAC_W-1:0] mac,
                                      input logic [VLAN_W-1:0] vlan);
      logic [31:0] h;
      h = {20'b0, vlan} ^ {16'b0, mac[15:0]} ^ mac[47:16];
      return int'(h % 32'(BUCKETS));
   endfunction

   // insert/update or delete against the shadow table, one word out per request
   function automatic learn_rsp_t learn_step(input logic func,
                                             input logic [MAC_W-1:0] mac,
                                             input logic [VLAN_W-1:0] vlan,
                                             input logic [PORT_W-1:0] port);
      learn_rsp_t           r;
      logic [KEY_W-1:0]     key;
      logic [PORT_BITS-1:0] p;
      int                   base;
      int                   hit;
      int                   free_way;
      key      = {vlan, mac};
      p        = port[PORT_BITS-1:0];
      base     = hash_bucket(mac, vlan) * WAYS;
      r.bucket = BUCKET_W'(hash_bucket(mac, vlan));
      hit      = -1;
      free_way = -1;
      if (func == OP_INSERT) begin
         for (int w = 0; w < WAYS; w++) begin
            if (tbl_valid[base + w]) begin
               if (hit < 0 && tbl_key[base + w] == key) hit = w;
            end else if (free_way < 0) begin
               free_way = w;
            end
         end
         if (hit >= 0) begin
            tbl_port[base + hit] = p;
            r.status = ST_UPDATED;
         end else if (free_way >= 0) begin
            tbl_valid[base + free_way] = 1'b1;
            tbl_key[base + free_way]   = key;
            tbl_port[base + free_way]  = p;
            r.status = ST_INSERTED;
         end else begin
            r.status = ST_FULL;
         end
      end else begin
         r.status = ST_NOT_FOUND;
         for (int w = 0; w < WAYS; w++) begin
            if (hit < 0 && tbl_valid[base + w] && tbl_key[base + w] == key &&
                tbl_port[base + w] == p) begin
               tbl_valid[base + w] = 1'b0;
               r.status = ST_DELETED;
               hit = w;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [MAC_W-1:0] twin_mac(input int k);
      return {32'(k), 16'(k)};
   endfunction

   // check returned words, then queue the expectation of each accepted request
   always @(posedge clock) begin
      learn_rsp_t want;
      learn_rsp_t model;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_rsp.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected rsp word: status %0d bucket %0d",
                           rsp_ch.status, rsp_ch.bucket);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.bucket !== want.bucket) begin
                  if (mismatches < 10)
                     $display("rsp mismatch: status exp %0d got %0d, bucket exp %0d got %0d",
                              want.status, rsp_ch.status, want.bucket, rsp_ch.bucket);
                  mismatches++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            model = learn_step(req_ch.func, req_ch.mac_addr, req_ch.vlan, req_ch.port);
            if (row_typed) begin
               model.status = row_status;
               model.bucket = row_bucket;
            end
            awaited_rsp.push_back(model);
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   // present one word, idling first at random, and hold it until taken
   task automatic send_word(input learn_row_t w);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.func     <= w.func;
      req_ch.mac_addr <= w.mac;
      req_ch.vlan     <= w.vlan;
      req_ch.port     <= w.port;
      row_typed       <= w.typed;
      row_status      <= w.status;
      row_bucket      <= w.bucket;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // mostly learning traffic aimed at a few hot buckets, some plain noise
   task automatic next_random_word(output learn_row_t w);
      learned_key_t k;
      int           roll;
      int           pick;
      roll   = $urandom_range(99);
      w      = '0;
      w.mac  = {16'($urandom), 32'($urandom)};
      w.vlan = 12'($urandom);
      w.port = 8'($urandom);
      if (roll < 10) begin
         w.func = 1'($urandom);
      end else if (roll < 50 || learned_keys.size() == 0) begin
         w.func = OP_INSERT;
         w.mac[BUCKET_W-1:0] ^= BUCKET_W'(hash_bucket(w.mac, w.vlan) ^
                                          hot_bucket[$urandom_range(HOT_N-1)]);
         k = '{w.mac, w.vlan, w.port};
         learned_keys.push_back(k);
         if (learned_keys.size() > KEY_POOL_MAX) void'(learned_keys.pop_front());
      end else begin
         pick   = $urandom_range(learned_keys.size() - 1);
         k      = learned_keys[pick];
         w.mac  = k.mac;
         w.vlan = k.vlan;
         if (roll < 72) begin
            w.func = OP_INSERT;
            learned_keys[pick].port = w.port;
         end else begin
            w.func = OP_DELETE;
            if ($urandom_range(4) != 0) w.port = k.port;
         end
      end
   endtask

   // stimulus
   initial begin
      learn_row_t w;
      req_ch.valid    = 1'b0;
      req_ch.func     = OP_INSERT;
      req_ch.mac_addr = '0;
      req_ch.vlan     = '0;
      req_ch.port     = '0;
      rsp_ch.ready    = 1'b0;
      row_typed       = 1'b0;
      row_status      = ST_INSERTED;
      row_bucket      = '0;
      do @(negedge clock); while (reset);

      // directed: empty table, update, port-checked delete, extremes, full bucket
      plan = '{
         '{OP_DELETE, 48'h0, 12'h000, 8'h00, 1'b1, ST_NOT_FOUND, 10'd0},
         '{OP_INSERT, 48'h0, 12'h000, 8'h00, 1'b1, ST_INSERTED,  10'd0},
         '{OP_INSERT, 48'h0, 12'h000, 8'hff, 1'b1, ST_UPDATED,   10'd0},
         '{OP_DELETE, 48'h0, 12'h000, 8'h00, 1'b1, ST_NOT_FOUND, 10'd0},
         '{OP_DELETE, 48'h0, 12'h000, 8'hff, 1'b1, ST_DELETED,   10'd0},
         '{OP_INSERT, 48'hffff_ffff_ffff, 12'hfff, 8'hff, 1'b1, ST_INSERTED, 10'd1023},
         '{OP_DELETE, 48'hffff_ffff_ffff, 12'hfff, 8'h00, 1'b1, ST_NOT_FOUND, 10'd1023},
         '{OP_INSERT, twin_mac(1), DIR_VLAN, 8'h01, 1'b0, ST_INSERTED, 10'd0},
         '{OP_INSERT, twin_mac(2), DIR_VLAN, 8'h02, 1'b0, ST_INSERTED, 10'd0},
         '{OP_INSERT, twin_mac(3), DIR_VLAN, 8'h03, 1'b0, ST_INSERTED, 10'd0},
         '{OP_INSERT, twin_mac(4), DIR_VLAN, 8'h04, 1'b0, ST_INSERTED, 10'd0},
         '{OP_INSERT, twin_mac(5), DIR_VLAN, 8'h05, 1'b1, ST_FULL, 10'd5},
         '{OP_INSERT, twin_mac(1), WIDE_VLAN, 8'h01, 1'b1, ST_FULL, 10'd5},
         '{OP_INSERT, twin_mac(1) | MAC_TOP, DIR_VLAN, 8'h01, 1'b1, ST_FULL, 10'd5},
         '{OP_DELETE, twin_mac(2), DIR_VLAN, 8'h02, 1'b0, ST_INSERTED, 10'd0},
         '{OP_DELETE, twin_mac(2), DIR_VLAN, 8'h02, 1'b1, ST_NOT_FOUND, 10'd5},
         '{OP_INSERT, twin_mac(5), DIR_VLAN, 8'h55, 1'b0, ST_INSERTED, 10'd0},
         '{OP_INSERT, twin_mac(5), DIR_VLAN, 8'haa, 1'b0, ST_INSERTED, 10'd0},
         '{OP_DELETE, twin_mac(5), DIR_VLAN, 8'h55, 1'b1, ST_NOT_FOUND, 10'd5},
         '{OP_INSERT, twin_mac(1), DIR_VLAN, 8'h07, 1'b0, ST_INSERTED, 10'd0},
         '{OP_DELETE, twin_mac(1), WIDE_VLAN, 8'h07, 1'b1, ST_NOT_FOUND, 10'd5},
         '{OP_DELETE, twin_mac(1), DIR_VLAN, 8'h07, 1'b0, ST_INSERTED, 10'd0}
      };
      foreach (plan[i]) send_word(plan[i]);

      // random phases with different idle mixes and fresh hot buckets
      for (int ph = 0; ph < PHASES; ph++) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         send_idle_pct  = SEND_IDLE_PCT[ph];
         recv_stall_pct = RECV_STALL_PCT[ph];
         foreach (hot_bucket[i]) hot_bucket[i] = $urandom_range(BUCKETS - 1);
         @(negedge clock);
         repeat (WORDS_PER_PHASE) begin
            next_random_word(w);
            send_word(w);
         end
      end
      req_ch.valid <= 1'b0;

      // drain
      while (awaited_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
